### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Concurrent assertion wrappers clocked on clock, with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside of reset.
`define CWT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every rising edge, reset included.
`define CWT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### src/cwt_pkg.sv
// ---------------------------------------------------------------------------
// Connectivity witness transition package
// Shared widths, codes and types of the witness transition unit.
// ---------------------------------------------------------------------------
`default_nettype none

package cwt_pkg;

   localparam int VERTEX_COUNT = 8;
   localparam int VERTEX_BITS  = 3;
   localparam int LABEL_BITS   = 3;
   localparam int LABELS_WIDTH = VERTEX_COUNT * LABEL_BITS;
   localparam int CLOSE_ROUNDS = $clog2(VERTEX_COUNT);
   localparam int BAG_SIZE_DEFAULT = 8;

   typedef logic [1:0]              action_type;
   typedef logic [1:0]              tag_type;
   typedef logic [VERTEX_COUNT-1:0] mask_type;
   typedef logic [LABELS_WIDTH-1:0] labels_type;
   typedef logic [VERTEX_BITS-1:0]  vertex_type;
   typedef logic [VERTEX_COUNT-1:0][VERTEX_COUNT-1:0] link_type;

   localparam action_type ACT_INTRO_VERTEX = 2'd0;
   localparam action_type ACT_INTRO_EDGE   = 2'd1;
   localparam action_type ACT_FORGET       = 2'd2;
   localparam action_type ACT_JOIN         = 2'd3;

   localparam tag_type TAG_EMPTY  = 2'd0;
   localparam tag_type TAG_OPEN   = 2'd1;
   localparam tag_type TAG_CLOSED = 2'd2;
   localparam tag_type TAG_BROKEN = 2'd3;

   // Prepared witness handed from the decode stage to the canonicalizer.
   typedef struct packed {
      tag_type  tag;
      mask_type pres;
      logic     err;
      link_type link;
   } prep_type;

endpackage

`default_nettype wire

### src/connectivity_witness_transition_unit.sv
// ---------------------------------------------------------------------------
// Connectivity witness transition unit
// Applies one tree-decomposition node operation to a connectivity witness.
// ---------------------------------------------------------------------------
// Usage:
//   A request carries an action code, one or two witnesses (tag, presence
//   mask, packed labels) and up to two vertex numbers. Each request yields
//   exactly one response: the resulting witness with canonical labels, an
//   accepting flag and an error flag.
//   Both channels use valid/ready; a transfer happens when both are high.
//   The request is held in the request register, then passes through the
//   decode and link-closure logic into the response register. Throughput:
//   one request per cycle, sustained while the receiver holds rsp_ready high.
//   While the receiver holds rsp_ready low the response register holds and
//   one more request can wait in the request register; req_ready drops only
//   when both are full and the response is not taken.
//   Reset empties both registers; no state survives between requests.
// ---------------------------------------------------------------------------
`default_nettype none

module connectivity_witness_transition_unit
   import cwt_pkg::*;
#(
   parameter int BAG_SIZE = BAG_SIZE_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire [1:0]  req_action,
   input  wire [1:0]  req_first_tag,
   input  wire [7:0]  req_first_present,
   input  wire [23:0] req_first_labels,
   input  wire [1:0]  req_second_tag,
   input  wire [7:0]  req_second_present,
   input  wire [23:0] req_second_labels,
   input  wire [2:0]  req_vertex_u,
   input  wire [2:0]  req_vertex_v,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [1:0]  rsp_out_tag,
   output logic [7:0]  rsp_out_present,
   output logic [23:0] rsp_out_labels,
   output logic        rsp_out_final,
   output logic        rsp_out_error
);

   `include "assert_macros.svh"

   logic       in_valid_ff;
   logic       in_valid_in;
   action_type in_action_ff;
   tag_type    in_first_tag_ff;
   mask_type   in_first_present_ff;
   labels_type in_first_labels_ff;
   tag_type    in_second_tag_ff;
   mask_type   in_second_present_ff;
   labels_type in_second_labels_ff;
   vertex_type in_vertex_u_ff;
   vertex_type in_vertex_v_ff;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   tag_type    rsp_tag_ff;
   mask_type   rsp_present_ff;
   labels_type rsp_labels_ff;
   logic       rsp_final_ff;
   logic       rsp_error_ff;

   logic       req_fire;
   logic       s1_fire;

   prep_type   prep;
   tag_type    nxt_tag;
   mask_type   nxt_present;
   labels_type nxt_labels;
   logic       nxt_final;
   logic       nxt_error;

   // Advance the request stage when the response register is free or drains.
   assign s1_fire   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = s1_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_action_ff         <= req_action;
         in_first_tag_ff      <= req_first_tag;
         in_first_present_ff  <= req_first_present;
         in_first_labels_ff   <= req_first_labels;
         in_second_tag_ff     <= req_second_tag;
         in_second_present_ff <= req_second_present;
         in_second_labels_ff  <= req_second_labels;
         in_vertex_u_ff       <= req_vertex_u;
         in_vertex_v_ff       <= req_vertex_v;
      end
   end

   cwt_prep #(
      .BAG_SIZE (BAG_SIZE)
   ) u_prep (
      .action         (in_action_ff),
      .first_tag      (in_first_tag_ff),
      .first_present  (in_first_present_ff),
      .first_labels   (in_first_labels_ff),
      .second_tag     (in_second_tag_ff),
      .second_present (in_second_present_ff),
      .second_labels  (in_second_labels_ff),
      .vertex_u       (in_vertex_u_ff),
      .vertex_v       (in_vertex_v_ff),
      .prep           (prep)
   );

   cwt_canon u_canon (
      .prep        (prep),
      .out_tag     (nxt_tag),
      .out_present (nxt_present),
      .out_labels  (nxt_labels),
      .out_final   (nxt_final),
      .out_error   (nxt_error)
   );

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_tag_ff     <= nxt_tag;
         rsp_present_ff <= nxt_present;
         rsp_labels_ff  <= nxt_labels;
         rsp_final_ff   <= nxt_final;
         rsp_error_ff   <= nxt_error;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_tag     = rsp_tag_ff;
   assign rsp_out_present = rsp_present_ff;
   assign rsp_out_labels  = rsp_labels_ff;
   assign rsp_out_final   = rsp_final_ff;
   assign rsp_out_error   = rsp_error_ff;

   `CWT_ASSERT_ALWAYS(a_full_blocks_req, (in_valid_ff && !s1_fire) |-> !req_ready, "request taken while request stage is stuck")
   `CWT_ASSERT(a_err_reaches_rsp, (s1_fire && prep.err) |=> (rsp_valid && rsp_out_error), "error lost between request and response stage")
   `CWT_ASSERT(a_empty_join, (s1_fire && in_action_ff == ACT_JOIN && in_first_tag_ff == TAG_EMPTY && in_second_tag_ff == TAG_EMPTY) |=> (rsp_out_present == '0 && rsp_out_tag == TAG_EMPTY && rsp_out_labels == '0), "join of empty witnesses not empty")
   `CWT_ASSERT(a_final_flag, rsp_valid |-> (rsp_out_final == (rsp_out_tag != TAG_BROKEN)), "accepting flag disagrees with tag")

endmodule

`default_nettype wire

### src/cwt_prep.sv
// ---------------------------------------------------------------------------
// Witness operation decode
// Applies the node operation: new tag, presence mask, error and cell links.
// ---------------------------------------------------------------------------
`default_nettype none

module cwt_prep
   import cwt_pkg::*;
#(
   parameter int BAG_SIZE = BAG_SIZE_DEFAULT
) (
   input  wire action_type action,
   input  wire tag_type    first_tag,
   input  wire mask_type   first_present,
   input  wire labels_type first_labels,
   input  wire tag_type    second_tag,
   input  wire mask_type   second_present,
   input  wire labels_type second_labels,
   input  wire vertex_type vertex_u,
   input  wire vertex_type vertex_v,
   output prep_type        prep
);

   mask_type bag_mask;
   mask_type p1;
   mask_type p2;
   mask_type m1;
   mask_type m2;
   mask_type bit_u;
   mask_type same_u;
   logic     u_in;
   logic     w_in;
   logic     u_oob;
   logic     edge_en;
   logic     single;
   logic [LABEL_BITS-1:0] u_label;
   link_type link;

   // Same-cell links of one witness: present pairs with equal labels.
   function automatic link_type label_links(mask_type m, labels_type l);
      link_type res;
      res = '0;
      for (int a = 0; a < VERTEX_COUNT; a++) begin
         for (int b = 0; b < VERTEX_COUNT; b++) begin
            res[a][b] = m[a] & m[b] &
                        (l[a*LABEL_BITS +: LABEL_BITS] == l[b*LABEL_BITS +: LABEL_BITS]);
         end
      end
      return res;
   endfunction

   always_comb begin
      for (int i = 0; i < VERTEX_COUNT; i++) begin
         bag_mask[i] = (i < BAG_SIZE);
      end
   end

   assign p1      = first_present & bag_mask;
   assign p2      = second_present & bag_mask;
   assign bit_u   = mask_type'(1) << vertex_u;
   assign u_in    = p1[vertex_u];
   assign w_in    = p1[vertex_v];
   assign u_oob   = (int'(vertex_u) >= BAG_SIZE);
   assign u_label = first_labels[vertex_u*LABEL_BITS +: LABEL_BITS];

   always_comb begin
      for (int a = 0; a < VERTEX_COUNT; a++) begin
         same_u[a] = p1[a] && (a != int'(vertex_u)) &&
                     (first_labels[a*LABEL_BITS +: LABEL_BITS] == u_label);
      end
   end

   assign single = ~|same_u;

   always_comb begin
      prep.tag  = first_tag;
      prep.pres = p1;
      prep.err  = 1'b0;
      m1        = p1;
      m2        = '0;
      edge_en   = 1'b0;
      unique case (action)
         ACT_INTRO_VERTEX: begin
            if (u_in || u_oob) begin
               prep.err = 1'b1;
            end else begin
               prep.tag  = first_tag | TAG_OPEN;
               prep.pres = p1 | bit_u;
            end
         end
         ACT_INTRO_EDGE: begin
            if (!u_in || !w_in) begin
               prep.err = 1'b1;
            end else begin
               edge_en = 1'b1;
            end
         end
         ACT_FORGET: begin
            if (!u_in) begin
               prep.err = 1'b1;
            end else begin
               // Dropping a lone open cell closes or breaks the witness.
               if (single && (first_tag == TAG_OPEN)) begin
                  prep.tag = ((p1 & ~bit_u) != '0) ? TAG_BROKEN : TAG_CLOSED;
               end
               prep.pres = p1 & ~bit_u;
               m1        = p1 & ~bit_u;
            end
         end
         ACT_JOIN: begin
            if ((first_tag == TAG_EMPTY) && (second_tag == TAG_EMPTY)) begin
               prep.tag  = TAG_EMPTY;
               prep.pres = '0;
               m1        = '0;
            end else begin
               if ((first_tag == TAG_EMPTY || first_tag == TAG_OPEN) &&
                   (second_tag == TAG_EMPTY || second_tag == TAG_OPEN)) begin
                  prep.tag = TAG_OPEN;
               end else if ((first_tag == TAG_EMPTY && second_tag == TAG_CLOSED) ||
                            (first_tag == TAG_CLOSED && second_tag == TAG_EMPTY)) begin
                  prep.tag = TAG_CLOSED;
               end else begin
                  prep.tag = TAG_BROKEN;
               end
               prep.pres = p1 | p2;
               m2        = p2;
            end
         end
      endcase

      link = label_links(m1, first_labels) | label_links(m2, second_labels);
      if (edge_en) begin
         link[vertex_u][vertex_v] = 1'b1;
         link[vertex_v][vertex_u] = 1'b1;
      end
      prep.link = link;
   end

endmodule

`default_nettype wire

### src/cwt_canon.sv
// ---------------------------------------------------------------------------
// Witness canonicalizer
// Closes the cell links and labels each present vertex with its cell minimum.
// ---------------------------------------------------------------------------
`default_nettype none

module cwt_canon
   import cwt_pkg::*;
(
   input  wire prep_type    prep,
   output tag_type          out_tag,
   output mask_type         out_present,
   output labels_type       out_labels,
   output logic             out_final,
   output logic             out_error
);

   link_type   reach [CLOSE_ROUNDS+1];
   labels_type labels;
   vertex_type root;

   always_comb begin
      reach[0] = prep.link;
      for (int a = 0; a < VERTEX_COUNT; a++) begin
         reach[0][a][a] = reach[0][a][a] | prep.pres[a];
      end
      // Square the reachability matrix; each round doubles the path length.
      for (int r = 0; r < CLOSE_ROUNDS; r++) begin
         for (int a = 0; a < VERTEX_COUNT; a++) begin
            reach[r+1][a] = reach[r][a];
            for (int b = 0; b < VERTEX_COUNT; b++) begin
               if (reach[r][a][b]) begin
                  reach[r+1][a] = reach[r+1][a] | reach[r][b];
               end
            end
         end
      end
   end

   always_comb begin
      labels = '0;
      root   = '0;
      for (int a = 0; a < VERTEX_COUNT; a++) begin
         root = '0;
         // Scan downward so the smallest member wins.
         for (int b = VERTEX_COUNT - 1; b >= 0; b--) begin
            if (reach[CLOSE_ROUNDS][a][b]) begin
               root = VERTEX_BITS'(b);
            end
         end
         labels[a*LABEL_BITS +: LABEL_BITS] = prep.pres[a] ? LABEL_BITS'(root) : '0;
      end
   end

   assign out_tag     = prep.tag;
   assign out_present = prep.pres;
   assign out_labels  = labels;
   assign out_final   = (prep.tag != TAG_BROKEN);
   assign out_error   = prep.err;

endmodule

`default_nettype wire
